### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file sbsm_checker.
// Each macro expands to one labeled concurrent assertion on the rising clock.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the synchronous reset is held.
`define SBSM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define SBSM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sbsm_pkg.sv
// ---------------------------------------------------------------------------
// sbsm_pkg
// Types, codes and constants of the serial bank switch mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package sbsm_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 16;
    localparam int VALUE_W = 8;
    localparam int MEM_W   = 18;

    typedef enum logic [OP_W-1:0] {
        OP_REG_WRITE = 2'd0,
        OP_PRG_READ  = 2'd1,
        OP_CHR_READ  = 2'd2,
        OP_CHR_WRITE = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRG_BANK_COUNT = 1'd0,
        CFG_CHR_USES_RAM   = 1'd1
    } t_cfg_reg;

    localparam logic [1:0]  MIRROR_HORIZONTAL = 2'd3;
    localparam logic [1:0]  PRG_MODE_FIX_LAST = 2'd3;
    localparam logic [1:0]  PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [2:0]  LOAD_LAST         = 3'd4;
    localparam logic [4:0]  MAX_PRG_BANKS     = 5'd16;
    localparam logic [15:0] CTRL_LIMIT        = 16'h9FFF;
    localparam logic [15:0] CHR0_LIMIT        = 16'hBFFF;
    localparam logic [15:0] CHR1_LIMIT        = 16'hDFFF;
    localparam logic [15:0] PRG_HIGH_BASE     = 16'hC000;
    localparam logic [15:0] CHR_HIGH_BASE     = 16'h1000;

    typedef struct packed {
        logic [4:0] load_shift;
        logic [2:0] load_count;
        logic [1:0] mirror_mode;
        logic       chr_mode;
        logic [1:0] prg_mode;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic [3:0] prg_bank;
    } t_map_state;

    typedef struct packed {
        logic [MEM_W-1:0] mem_address;
        logic [1:0]       mirroring;
        logic             mirroring_changed;
        logic             write_refused;
    } t_result;

endpackage

`default_nettype wire

### rtl/sbsm_step.sv
// ---------------------------------------------------------------------------
// sbsm_step
// Next mapper state and result of one bus access, from the current state.
// ---------------------------------------------------------------------------
`default_nettype none

module sbsm_step (
    input  wire sbsm_pkg::t_op                  i_op,
    input  wire [sbsm_pkg::ADDR_W-1:0]          i_addr,
    input  wire [sbsm_pkg::VALUE_W-1:0]         i_value,
    input  wire [3:0]                           i_prg_last,
    input  wire                                 i_chr_ram,
    input  wire sbsm_pkg::t_map_state           i_state,
    output sbsm_pkg::t_map_state                o_state,
    output sbsm_pkg::t_result                   o_result
);

    logic [4:0] shift_in;
    logic [3:0] prg_bank_sel;
    logic [4:0] chr_bank_sel;
    logic       prg_second;
    logic       chr_high;
    logic [sbsm_pkg::MEM_W-1:0] prg_addr;
    logic [sbsm_pkg::MEM_W-1:0] chr_addr;

    assign prg_second = (i_addr >= sbsm_pkg::PRG_HIGH_BASE);
    assign chr_high   = (i_addr >= sbsm_pkg::CHR_HIGH_BASE);
    assign shift_in   = {i_value[0], i_state.load_shift[4:1]};

    // PRG window: modes 0 and 1 switch 32KB at once.
    always_comb begin
        case (i_state.prg_mode)
            sbsm_pkg::PRG_MODE_FIX_LAST: begin
                prg_bank_sel = prg_second ? i_prg_last : i_state.prg_bank;
            end
            sbsm_pkg::PRG_MODE_FIX_FIRST: begin
                prg_bank_sel = prg_second ? i_state.prg_bank : 4'd0;
            end
            default: begin
                prg_bank_sel = {i_state.prg_bank[3:1], prg_second};
            end
        endcase
    end

    always_comb begin
        if (i_state.chr_mode) begin
            chr_bank_sel = chr_high ? i_state.chr_bank_high : i_state.chr_bank_low;
        end else begin
            chr_bank_sel = {i_state.chr_bank_low[4:1], chr_high};
        end
    end

    assign prg_addr = {prg_bank_sel, i_addr[13:0]};

    // CHR RAM is 8KB and passes the address through.
    assign chr_addr = i_chr_ram ? {5'd0, i_addr[12:0]}
                                : {1'b0, chr_bank_sel, i_addr[11:0]};

    always_comb begin
        o_state                    = i_state;
        o_result.mem_address       = '0;
        o_result.mirroring_changed = 1'b0;
        o_result.write_refused     = 1'b0;
        unique case (i_op)
            sbsm_pkg::OP_REG_WRITE: begin
                if (i_value[7]) begin
                    o_state.load_shift = '0;
                    o_state.load_count = '0;
                    o_state.prg_mode   = sbsm_pkg::PRG_MODE_FIX_LAST;
                end else if (i_state.load_count == sbsm_pkg::LOAD_LAST) begin
                    // Fifth bit: commit to the register picked by the address.
                    o_state.load_shift = '0;
                    o_state.load_count = '0;
                    if (i_addr <= sbsm_pkg::CTRL_LIMIT) begin
                        o_state.mirror_mode        = shift_in[1:0];
                        o_state.prg_mode           = shift_in[3:2];
                        o_state.chr_mode           = shift_in[4];
                        o_result.mirroring_changed = 1'b1;
                    end else if (i_addr <= sbsm_pkg::CHR0_LIMIT) begin
                        o_state.chr_bank_low = shift_in;
                    end else if (i_addr <= sbsm_pkg::CHR1_LIMIT) begin
                        o_state.chr_bank_high = shift_in;
                    end else begin
                        o_state.prg_bank = shift_in[3:0];
                    end
                end else begin
                    o_state.load_shift = shift_in;
                    o_state.load_count = i_state.load_count + 3'd1;
                end
            end
            sbsm_pkg::OP_PRG_READ: begin
                o_result.mem_address = prg_addr;
            end
            sbsm_pkg::OP_CHR_READ: begin
                o_result.mem_address = chr_addr;
            end
            sbsm_pkg::OP_CHR_WRITE: begin
                o_result.mem_address   = chr_addr;
                o_result.write_refused = ~i_chr_ram;
            end
            default: begin
                o_result.mem_address = '0;
            end
        endcase
        o_result.mirroring = o_state.mirror_mode;
    end

endmodule

`default_nettype wire

### rtl/serial_bank_switch_mapper_core.sv
// ---------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Cartridge bank mapper with a five-bit serial load register.
// ---------------------------------------------------------------------------
// The block takes one bus access beat per cycle unless stalled and returns one
// result beat for each: the beat is captured in an input register, the mapper
// state and translated address are worked out from it combinationally, and
// the result waits in an output register. Both registers move
// together, so the block keeps accepting while the output side is ready and
// stalls only when the result register is full and not taken.
`default_nettype none

module serial_bank_switch_mapper_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [sbsm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [sbsm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // op [1:0], addr [17:2], value [25:18], zero [31:26]
    input  wire [sbsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // mem_address [17:0], mirroring [19:18], mirroring_changed [20],
    // write_refused [21], zero [23:22]
    output logic [sbsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic                               r_s1_valid;
    sbsm_pkg::t_op                      r_s1_op;
    logic [sbsm_pkg::ADDR_W-1:0]        r_s1_addr;
    logic [sbsm_pkg::VALUE_W-1:0]       r_s1_value;
    logic                               r_out_valid;
    sbsm_pkg::t_result                  r_out;
    sbsm_pkg::t_map_state               r_state;
    sbsm_pkg::t_map_state               n_state;
    sbsm_pkg::t_result                  n_out;
    logic [3:0]                         r_prg_last;
    logic                               r_chr_ram;
    logic                               s1_fire;
    logic                               in_fire;

    assign s1_fire       = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | s1_fire;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    // Configuration: the bank count is kept as the clamped index of the last bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_last <= 4'd15;
            r_chr_ram  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (sbsm_pkg::t_cfg_reg'(i_cfg_index))
                sbsm_pkg::CFG_PRG_BANK_COUNT: begin
                    if (i_cfg_wdata == 5'd0) begin
                        r_prg_last <= 4'd0;
                    end else if (i_cfg_wdata > sbsm_pkg::MAX_PRG_BANKS) begin
                        r_prg_last <= 4'd15;
                    end else begin
                        r_prg_last <= 4'(i_cfg_wdata - 5'd1);
                    end
                end
                sbsm_pkg::CFG_CHR_USES_RAM: begin
                    r_chr_ram <= i_cfg_wdata[0];
                end
                default: begin
                    r_chr_ram <= r_chr_ram;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op    <= sbsm_pkg::t_op'(s_axis_tdata[1:0]);
            r_s1_addr  <= s_axis_tdata[17:2];
            r_s1_value <= s_axis_tdata[25:18];
        end
    end

    sbsm_step u_step (
        .i_op       (r_s1_op),
        .i_addr     (r_s1_addr),
        .i_value    (r_s1_value),
        .i_prg_last (r_prg_last),
        .i_chr_ram  (r_chr_ram),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.load_shift    <= '0;
            r_state.load_count    <= '0;
            r_state.mirror_mode   <= sbsm_pkg::MIRROR_HORIZONTAL;
            r_state.chr_mode      <= 1'b0;
            r_state.prg_mode      <= sbsm_pkg::PRG_MODE_FIX_LAST;
            r_state.chr_bank_low  <= '0;
            r_state.chr_bank_high <= '0;
            r_state.prg_bank      <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.write_refused, r_out.mirroring_changed,
                            r_out.mirroring, r_out.mem_address};

endmodule

`default_nettype wire

### rtl/sbsm_checker.sv
// ---------------------------------------------------------------------------
// sbsm_checker
// Port-level checks of the mapper core, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbsm_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [sbsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    `SBSM_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `SBSM_ASSERT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result beat changed")
    `SBSM_ASSERT(a_commit_no_addr, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[17:0] == 18'd0, "register commit carries an address")
    `SBSM_ASSERT(a_flags_exclusive, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tdata[20] && m_axis_tdata[21]), "commit and refused flags together")

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_sbsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
